[sv/tma_pkg.sv]
// Package for the transform matrix accumulator: widths, codes, CORDIC constants,
// the structs passed between the submodules and the step matrix element function.
// No dependencies.
`default_nettype none

package tma_pkg;

    localparam int EW           = 32;
    localparam int DIM          = 4;
    localparam int FRAC_BITS    = 16;
    localparam int HALF_TURN    = 180;
    localparam int CORDIC_ITERS = 24;
    localparam int MOD_STEPS    = 8;
    localparam int CW           = 34;
    localparam int PROD_W       = 64;
    localparam int TERM_W       = 48;
    localparam int ACC_W        = 50;

    localparam logic signed [EW-1:0] ONE_Q16     = EW'(1 << FRAC_BITS);
    localparam logic signed [CW-1:0] FULL_DEG    = CW'(2 * HALF_TURN * 65536);
    localparam logic signed [CW-1:0] HALF_DEG    = CW'(HALF_TURN * 65536);
    localparam logic signed [CW-1:0] QUARTER_DEG = CW'(HALF_TURN * 65536 / 2);
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

    typedef enum logic [2:0] {
        K_IDENT     = 3'd0,
        K_TRANSLATE = 3'd1,
        K_SCALE     = 3'd2,
        K_ROT_X     = 3'd3,
        K_ROT_Y     = 3'd4,
        K_ROT_Z     = 3'd5,
        K_READ      = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_ROW_READ,
        ST_ROW_ISSUE,
        ST_DRAIN,
        ST_READ_OUT
    } t_tma_state;

    typedef enum logic [2:0] {
        COR_IDLE,
        COR_MOD,
        COR_FOLD,
        COR_ITER,
        COR_DONE
    } t_cor_state;

    typedef struct packed {
        logic       vld;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] k;
    } t_mac_issue;

    typedef struct packed {
        logic          en;
        logic [3:0]    addr;
        logic [EW-1:0] data;
    } t_mem_wr;

    // Arctangent of 2^-i in Q10.24 degrees.
    function automatic logic signed [CW-1:0] f_atan(input logic [4:0] i);
        logic signed [CW-1:0] v;
        begin
            unique case (i)
                5'd0:    v = CW'(754974720);
                5'd1:    v = CW'(445687602);
                5'd2:    v = CW'(235489089);
                5'd3:    v = CW'(119537938);
                5'd4:    v = CW'(60000935);
                5'd5:    v = CW'(30029717);
                5'd6:    v = CW'(15018523);
                5'd7:    v = CW'(7509720);
                5'd8:    v = CW'(3754917);
                5'd9:    v = CW'(1877466);
                5'd10:   v = CW'(938734);
                5'd11:   v = CW'(469367);
                5'd12:   v = CW'(234684);
                5'd13:   v = CW'(117342);
                5'd14:   v = CW'(58671);
                5'd15:   v = CW'(29335);
                5'd16:   v = CW'(14668);
                5'd17:   v = CW'(7334);
                5'd18:   v = CW'(3667);
                5'd19:   v = CW'(1833);
                5'd20:   v = CW'(917);
                5'd21:   v = CW'(458);
                5'd22:   v = CW'(229);
                5'd23:   v = CW'(115);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Element (k, c) of the matrix that right-multiplies the held matrix.
    function automatic logic signed [EW-1:0] f_step(
        input t_kind                kind,
        input logic [1:0]           k,
        input logic [1:0]           c,
        input logic signed [EW-1:0] a,
        input logic signed [EW-1:0] b,
        input logic signed [EW-1:0] cc,
        input logic signed [EW-1:0] s,
        input logic signed [EW-1:0] co
    );
        logic signed [EW-1:0] v;
        begin
            v = (k == c) ? ONE_Q16 : '0;
            unique case (kind)
                K_TRANSLATE: begin
                    if (c == 2'd3 && k == 2'd0) v = a;
                    if (c == 2'd3 && k == 2'd1) v = b;
                    if (c == 2'd3 && k == 2'd2) v = cc;
                end
                K_SCALE: begin
                    if (c == k && k == 2'd0) v = a;
                    if (c == k && k == 2'd1) v = b;
                    if (c == k && k == 2'd2) v = cc;
                end
                K_ROT_X: begin
                    if (k == 2'd1 && c == 2'd1) v = co;
                    if (k == 2'd1 && c == 2'd2) v = -s;
                    if (k == 2'd2 && c == 2'd1) v = s;
                    if (k == 2'd2 && c == 2'd2) v = co;
                end
                K_ROT_Y: begin
                    if (k == 2'd0 && c == 2'd0) v = co;
                    if (k == 2'd2 && c == 2'd0) v = -s;
                    if (k == 2'd0 && c == 2'd2) v = s;
                    if (k == 2'd2 && c == 2'd2) v = co;
                end
                K_ROT_Z: begin
                    if (k == 2'd0 && c == 2'd0) v = co;
                    if (k == 2'd0 && c == 2'd1) v = -s;
                    if (k == 2'd1 && c == 2'd0) v = s;
                    if (k == 2'd1 && c == 2'd1) v = co;
                end
                default: ;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

[sv/tma_req_if.sv]
// Request channel of the transform matrix accumulator: valid, ready and one command.
// No dependencies.
`default_nettype none

interface tma_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] operand_c;

    modport source (output valid, kind, operand_a, operand_b, operand_c, input ready);
    modport sink   (input valid, kind, operand_a, operand_b, operand_c, output ready);
endinterface

`default_nettype wire

[sv/tma_res_if.sv]
// Result channel of the transform matrix accumulator: one matrix element per handshake.
// No dependencies.
`default_nettype none

interface tma_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] element;
    logic [1:0]         row;
    logic [1:0]         column;
    logic               last;

    modport source (output valid, element, row, column, last, input ready);
    modport sink   (input valid, element, row, column, last, output ready);
endinterface

`default_nettype wire

[sv/tma_mem.sv]
// Matrix store: 16 elements addressed {column, row}, one read and one write port,
// registered read data; entries never written since the last clear read as identity.
`default_nettype none

module tma_mem import tma_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_rd_en,
    input  logic [3:0]           i_rd_addr,
    input  t_mem_wr              i_wr,
    output logic signed [EW-1:0] o_rd_data
);

    logic [EW-1:0]        r_mem [DIM*DIM];
    logic [DIM*DIM-1:0]   r_valid;
    logic [EW-1:0]        r_rd_data;
    logic                 r_rd_vld;
    logic                 r_rd_diag;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_valid[i_rd_addr];
            r_rd_diag <= (i_rd_addr[3:2] == i_rd_addr[1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld  ? r_rd_data :
                       r_rd_diag ? ONE_Q16   : '0;

endmodule

`default_nettype wire

[sv/tma_mac.sv]
// Multiply, round and accumulate pipeline for one matrix row: holds the row operands,
// forms one product a cycle and writes each saturated sum back through t_mem_wr.
`default_nettype none

module tma_mac import tma_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [1:0]           i_load_k,
    input  logic signed [EW-1:0] i_load_data,
    input  t_mac_issue           i_issue,
    input  logic signed [EW-1:0] i_step,
    output t_mem_wr              o_wr,
    output logic                 o_busy
);

    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-EW+1){1'b0}}, {(EW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-EW+1){1'b1}}, {(EW-1){1'b0}}};

    logic signed [EW-1:0]     r_m [DIM];
    t_mac_issue               r_s1;
    t_mac_issue               r_s2;
    t_mac_issue               r_s3;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [TERM_W-1:0] r_term;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     w_neg;
    logic [PROD_W-1:0]        w_mag;
    logic [PROD_W-1:0]        w_sum;
    logic [TERM_W-1:0]        w_rnd;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_m[i_load_k] <= i_load_data;
        end
    end

    always_comb begin
        w_neg = r_prod[PROD_W-1];
        w_mag = w_neg ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        w_sum = w_mag + PROD_W'(1 << (FRAC_BITS - 1));
        w_rnd = TERM_W'(w_sum >> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s1 <= i_issue;
            r_s2 <= r_s1;
            r_s3 <= '{vld: r_s2.vld && (r_s2.k == 2'd3), row: r_s2.row,
                      col: r_s2.col, k: r_s2.k};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_m[i_issue.k]) * PROD_W'(i_step);
        r_term <= w_neg ? -$signed(w_rnd) : $signed(w_rnd);
        if (r_s2.k == 2'd0) begin
            r_acc <= ACC_W'(r_term);
        end else begin
            r_acc <= r_acc + ACC_W'(r_term);
        end
    end

    always_comb begin
        o_wr.en   = r_s3.vld;
        o_wr.addr = {r_s3.col, r_s3.row};
        if (r_acc > SAT_HI) begin
            o_wr.data = SAT_HI[EW-1:0];
        end else if (r_acc < SAT_LO) begin
            o_wr.data = SAT_LO[EW-1:0];
        end else begin
            o_wr.data = r_acc[EW-1:0];
        end
    end

    assign o_busy = r_s1.vld || r_s2.vld || r_s3.vld;

endmodule

`default_nettype wire

[sv/tma_cordic.sv]
// Sine and cosine of an angle in Q16.16 degrees: reduction modulo a full turn by
// shifted subtraction, fold into a quarter turn, then iterative rotation CORDIC.
`default_nettype none

module tma_cordic import tma_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [EW-1:0] i_angle,
    output logic                 o_done,
    output logic signed [EW-1:0] o_sin,
    output logic signed [EW-1:0] o_cos
);

    t_cor_state           r_state;
    t_cor_state           n_state;
    logic [4:0]           r_cnt;
    logic                 r_neg;
    logic                 r_flip;
    logic signed [CW-1:0] r_rem;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;

    logic signed [CW-1:0] w_ang;
    logic signed [CW-1:0] w_sub;
    logic signed [CW-1:0] w_r0;
    logic signed [CW-1:0] w_r1;
    logic signed [CW-1:0] w_r2;
    logic                 w_flip;
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic signed [CW-1:0] w_at;
    logic signed [CW-1:0] w_xr;
    logic signed [CW-1:0] w_yr;
    logic signed [CW-1:0] w_c;
    logic signed [CW-1:0] w_s;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            COR_IDLE: if (i_start) n_state = COR_MOD;
            COR_MOD:  if (r_cnt == 5'd0) n_state = COR_FOLD;
            COR_FOLD: n_state = COR_ITER;
            COR_ITER: if (r_cnt == 5'(CORDIC_ITERS - 1)) n_state = COR_DONE;
            COR_DONE: n_state = COR_IDLE;
            default:  n_state = COR_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == COR_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= COR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        w_ang = CW'(i_angle);
        w_sub = FULL_DEG <<< r_cnt[2:0];
        w_r0  = (r_neg && r_rem != '0) ? FULL_DEG - r_rem : r_rem;
        w_r1  = (w_r0 > HALF_DEG) ? w_r0 - FULL_DEG : w_r0;
        w_r2  = w_r1;
        w_flip = 1'b0;
        if (w_r1 > QUARTER_DEG) begin
            w_r2   = w_r1 - HALF_DEG;
            w_flip = 1'b1;
        end else if (w_r1 < -QUARTER_DEG) begin
            w_r2   = w_r1 + HALF_DEG;
            w_flip = 1'b1;
        end
        w_dx = r_y >>> r_cnt;
        w_dy = r_x >>> r_cnt;
        w_at = f_atan(r_cnt);
        w_xr = (r_x + CW'(8192)) >>> 14;
        w_yr = (r_y + CW'(8192)) >>> 14;
        w_c  = r_flip ? -w_xr : w_xr;
        w_s  = r_flip ? -w_yr : w_yr;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            COR_IDLE: begin
                r_neg <= i_angle[EW-1];
                r_rem <= i_angle[EW-1] ? -w_ang : w_ang;
                r_cnt <= 5'(MOD_STEPS - 1);
            end
            COR_MOD: begin
                if (r_rem >= w_sub) begin
                    r_rem <= r_rem - w_sub;
                end
                r_cnt <= r_cnt - 5'd1;
            end
            COR_FOLD: begin
                r_z    <= w_r2 <<< 8;
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_flip <= w_flip;
                r_cnt  <= '0;
            end
            COR_ITER: begin
                if (r_z >= 0) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end
                r_cnt <= r_cnt + 5'd1;
            end
            default: ;
        endcase
    end

    assign o_cos = w_c[EW-1:0];
    assign o_sin = w_s[EW-1:0];

endmodule

`default_nettype wire

[sv/transform_matrix_accumulator_unit.sv]
// Transform matrix accumulator: top level with the command sequencer and readout.
// Depends on tma_pkg, tma_req_if, tma_res_if, tma_mem, tma_mac and tma_cordic.
//
// Usage. i_req carries one request per valid/ready handshake: kind selects identity,
// translate, scale, rotate about X, Y or Z, or read; operands are Q16.16. The matrix
// starts as the identity after reset; i_rst_n is synchronous and active low.
// o_res carries the sixteen elements of a read request in column-major order with row
// and column on each and last on the final element; other requests give no result.
// Timing. Identity and unknown kinds leave the sequencer idle and ready again in the
// cycle after they are taken. Translate and scale work through four rows, each read
// from the matrix store's one read port and then sixteen products through the one
// shared multiplier, then a drain of the multiply pipeline. Rotations first run the
// angle reduction, the fold and the 24 CORDIC iterations. A read fetches each element
// from the store only when no earlier fetch is still in flight and the output register
// is free, so fetches never overlap. A stall on o_res holds the current element and
// pauses fetching; a request is taken only when idle, and the last element may still
// wait in the output register while the next request is taken.
`default_nettype none

module transform_matrix_accumulator_unit import tma_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tma_req_if.sink     i_req,
    tma_res_if.source   o_res
);

    t_tma_state           r_state;
    t_tma_state           n_state;
    logic [3:0]           r_cnt;
    logic [3:0]           n_cnt;
    logic [1:0]           r_row;
    logic [1:0]           n_row;
    t_kind                r_kind;
    logic signed [EW-1:0] r_a;
    logic signed [EW-1:0] r_b;
    logic signed [EW-1:0] r_c;
    logic signed [EW-1:0] r_sin;
    logic signed [EW-1:0] r_cos;
    logic                 r_cap_vld;
    logic [1:0]           r_cap_k;
    logic                 r_rd_pend;
    logic [3:0]           r_rd_idx;
    logic                 r_out_vld;
    logic signed [EW-1:0] r_out_elem;
    logic [1:0]           r_out_row;
    logic [1:0]           r_out_col;
    logic                 r_out_last;

    logic                 w_accept;
    t_kind                w_kind;
    logic                 w_clear;
    logic                 w_cor_start;
    logic                 w_cor_done;
    logic signed [EW-1:0] w_sin;
    logic signed [EW-1:0] w_cos;
    logic                 w_rd_en;
    logic [3:0]           w_rd_addr;
    logic signed [EW-1:0] w_rd_data;
    logic                 w_ro_issue;
    logic                 w_advance;
    t_mac_issue           w_issue;
    logic signed [EW-1:0] w_step;
    t_mem_wr              w_wr;
    logic                 w_busy;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_kind   = t_kind'(i_req.kind);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_kind)
                        K_TRANSLATE, K_SCALE:      n_state = ST_ROW_READ;
                        K_ROT_X, K_ROT_Y, K_ROT_Z: n_state = ST_CORDIC;
                        K_READ:                    n_state = ST_READ_OUT;
                        default:                   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CORDIC:    if (w_cor_done) n_state = ST_ROW_READ;
            ST_ROW_READ:  if (r_cnt == 4'd3) n_state = ST_ROW_ISSUE;
            ST_ROW_ISSUE: begin
                if (r_cnt == 4'd15) begin
                    n_state = (r_row == 2'd3) ? ST_DRAIN : ST_ROW_READ;
                end
            end
            ST_DRAIN:     if (!w_busy) n_state = ST_IDLE;
            ST_READ_OUT:  if (w_ro_issue && r_cnt == 4'd15) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready  = (r_state == ST_IDLE);
        w_clear      = w_accept && (w_kind == K_IDENT);
        w_cor_start  = w_accept && (w_kind == K_ROT_X || w_kind == K_ROT_Y ||
                                    w_kind == K_ROT_Z);
        w_ro_issue   = (r_state == ST_READ_OUT) && !r_rd_pend &&
                       (!r_out_vld || o_res.ready);
        w_rd_en      = (r_state == ST_ROW_READ) || w_ro_issue;
        w_rd_addr    = (r_state == ST_ROW_READ) ? {r_cnt[1:0], r_row} : r_cnt;
        w_issue.vld  = (r_state == ST_ROW_ISSUE);
        w_issue.row  = r_row;
        w_issue.col  = r_cnt[3:2];
        w_issue.k    = r_cnt[1:0];
        w_advance    = (r_state == ST_ROW_READ) || (r_state == ST_ROW_ISSUE) || w_ro_issue;
        n_cnt        = (n_state != r_state) ? 4'd0 :
                       (w_advance ? r_cnt + 4'd1 : r_cnt);
        n_row        = r_row;
        if (w_accept) begin
            n_row = 2'd0;
        end else if (r_state == ST_ROW_ISSUE && r_cnt == 4'd15) begin
            n_row = r_row + 2'd1;
        end
    end

    assign w_step = f_step(r_kind, w_issue.k, w_issue.col, r_a, r_b, r_c, r_sin, r_cos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_row     <= '0;
            r_cap_vld <= 1'b0;
            r_rd_pend <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_row     <= n_row;
            r_cap_vld <= (r_state == ST_ROW_READ);
            r_rd_pend <= w_ro_issue;
            if (r_rd_pend) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap_k <= r_cnt[1:0];
        if (w_accept) begin
            r_kind <= w_kind;
            r_a    <= i_req.operand_a;
            r_b    <= i_req.operand_b;
            r_c    <= i_req.operand_c;
        end
        if (w_cor_done) begin
            r_sin <= w_sin;
            r_cos <= w_cos;
        end
        if (w_ro_issue) begin
            r_rd_idx <= r_cnt;
        end
        if (r_rd_pend) begin
            r_out_elem <= w_rd_data;
            r_out_row  <= r_rd_idx[1:0];
            r_out_col  <= r_rd_idx[3:2];
            r_out_last <= (r_rd_idx == 4'd15);
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.element = r_out_elem;
    assign o_res.row     = r_out_row;
    assign o_res.column  = r_out_col;
    assign o_res.last    = r_out_last;

    tma_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr      (w_wr),
        .o_rd_data (w_rd_data)
    );

    tma_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (r_cap_vld),
        .i_load_k    (r_cap_k),
        .i_load_data (w_rd_data),
        .i_issue     (w_issue),
        .i_step      (w_step),
        .o_wr        (w_wr),
        .o_busy      (w_busy)
    );

    tma_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_angle (i_req.operand_a),
        .o_done  (w_cor_done),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

`ifndef ASSERT_OFF
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !w_busy)
        else $error("request taken while the multiply pipeline still holds work");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ_OUT) |-> !w_wr.en)
        else $error("matrix store written during a readout");

    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |-> (o_res.row == 2'd3 && o_res.column == 2'd3))
        else $error("last flag on an element other than row 3, column 3");
`endif

endmodule

`default_nettype wire

[test/tma_checker.sv]
// Checker for the transform matrix accumulator: watches both channels, keeps its own
// copy of the matrix, predicts every read and compares each element. Depends on tma_pkg
// and the request and result interfaces.
`timescale 1ns / 100ps

module tma_checker import tma_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tma_req_if.sink   req_mon,
    tma_res_if.sink   res_mon,
    output int        o_errors,
    output int        o_pending
);

    typedef struct {
        logic signed [31:0] element;
        logic [1:0]         row;
        logic [1:0]         column;
        logic               last;
    } t_elem;

    typedef longint t_mat [4][4];

    t_mat  held;
    t_elem elems_due [$];

    longint atan_q24 [24] = '{
        754974720, 445687602, 235489089, 119537938, 60000935, 30029717, 15018523,
        7509720, 3754917, 1877466, 938734, 469367, 234684, 117342, 58671, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115};

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint q16_product(longint a, longint b);
        longint ma;
        longint mb;
        longint p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb + 32768) >> 16;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic void identity(ref t_mat m);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = (r == c) ? 65536 : 0;
    endfunction

    function automatic void angle_sin_cos(longint deg, output longint s, output longint co);
        longint full;
        longint half;
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        full = 360 * 65536;
        half = 180 * 65536;
        r = deg % full;
        x = 652032874;
        y = 0;
        flip = 0;
        if (r < 0) r += full;
        if (r > half) r -= full;
        if (r > half / 2) begin
            r -= half;
            flip = 1;
        end else if (r < -half / 2) begin
            r += half;
            flip = 1;
        end
        z = r * 256;
        for (int i = 0; i < 24; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_q24[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_q24[i];
            end
        end
        x = floor_sh(x + 8192, 14);
        y = floor_sh(y + 8192, 14);
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        co = x;
    endfunction

    function automatic void apply_request(logic [2:0] kind, longint a, longint b, longint c);
        t_mat   stp;
        t_mat   nxt;
        longint s;
        longint co;
        longint acc;
        t_elem  e;
        identity(stp);
        case (kind)
            K_IDENT: begin
                identity(held);
                return;
            end
            K_TRANSLATE: begin
                stp[0][3] = a;
                stp[1][3] = b;
                stp[2][3] = c;
            end
            K_SCALE: begin
                stp[0][0] = a;
                stp[1][1] = b;
                stp[2][2] = c;
            end
            K_ROT_X: begin
                angle_sin_cos(a, s, co);
                stp[1][1] = co; stp[1][2] = -s; stp[2][1] = s; stp[2][2] = co;
            end
            K_ROT_Y: begin
                angle_sin_cos(a, s, co);
                stp[0][0] = co; stp[2][0] = -s; stp[0][2] = s; stp[2][2] = co;
            end
            K_ROT_Z: begin
                angle_sin_cos(a, s, co);
                stp[0][0] = co; stp[0][1] = -s; stp[1][0] = s; stp[1][1] = co;
            end
            K_READ: begin
                for (int k = 0; k < 16; k++) begin
                    e.element = held[k % 4][k / 4][31:0];
                    e.row = 2'(k % 4);
                    e.column = 2'(k / 4);
                    e.last = (k == 15);
                    elems_due.push_back(e);
                end
                return;
            end
            default: return;
        endcase
        for (int r = 0; r < 4; r++)
            for (int cc = 0; cc < 4; cc++) begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += q16_product(held[r][k], stp[k][cc]);
                if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                nxt[r][cc] = acc;
            end
        held = nxt;
    endfunction

    assign o_pending = elems_due.size();

    always @(posedge i_clk) begin
        t_elem e;
        if (!i_rst_n) begin
            identity(held);
            elems_due.delete();
            o_errors <= 0;
        end else begin
            if (res_mon.valid && res_mon.ready) begin
                if (elems_due.size() == 0) begin
                    $display("%t: unexpected element %h row %0d column %0d", $time,
                             res_mon.element, res_mon.row, res_mon.column);
                    o_errors <= o_errors + 1;
                end else begin
                    e = elems_due.pop_front();
                    if (res_mon.element !== e.element || res_mon.row !== e.row ||
                        res_mon.column !== e.column || res_mon.last !== e.last) begin
                        $display("%t: expected %h r%0d c%0d l%0d, actual %h r%0d c%0d l%0d",
                                 $time, e.element, e.row, e.column, e.last, res_mon.element,
                                 res_mon.row, res_mon.column, res_mon.last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (req_mon.valid && req_mon.ready)
                apply_request(req_mon.kind, longint'(req_mon.operand_a),
                              longint'(req_mon.operand_b), longint'(req_mon.operand_c));
        end
    end

endmodule

[test/tb.sv]
// Testbench top for the transform matrix accumulator: drives directed and random
// requests under idling and stall phases and gives the verdict. Depends on tma_pkg,
// the request and result interfaces, tma_checker and the block.
`timescale 1ns / 100ps

module tb import tma_pkg::*;;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   send_idle = 0;
    int   recv_stall = 0;

    tma_req_if req ();
    tma_res_if res ();

    transform_matrix_accumulator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req.sink), .o_res(res.source));

    tma_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req_mon(req.sink), .res_mon(res.sink),
        .o_errors(errors), .o_pending(pending));

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk)
        res.ready <= ($urandom_range(99) >= recv_stall);

    task automatic send(logic [2:0] kind, logic [31:0] a, logic [31:0] b, logic [31:0] c);
        while ($urandom_range(99) < send_idle) begin
            req.valid <= 0;
            @(negedge i_clk);
        end
        req.valid <= 1;
        req.kind <= kind;
        req.operand_a <= a;
        req.operand_b <= b;
        req.operand_c <= c;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_operand(logic [2:0] kind);
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'(int'($urandom_range(720)) - 360) << 16;
            2: return 32'h0001_0000 + $urandom_range(32'h4000) - 32'h2000;
            3: return kind >= K_ROT_X ? $urandom_range(32'h0400_0000) : $urandom_range(32'h1_0000);
            4: return -($urandom_range(32'h2_0000));
            default: return $urandom_range(32'h3_0000);
        endcase
    endfunction

    task automatic random_item();
        logic [2:0] kind;
        int         sel;
        sel = $urandom_range(99);
        if (sel < 5) kind = K_IDENT;
        else if (sel < 30) kind = K_READ;
        else if (sel < 32) kind = 3'd7;
        else kind = 3'($urandom_range(K_TRANSLATE, K_ROT_Z));
        send(kind, rand_operand(kind), rand_operand(kind), rand_operand(kind));
    endtask

    initial begin
        req.valid = 0;
        req.kind = K_IDENT;
        req.operand_a = 0;
        req.operand_b = 0;
        req.operand_c = 0;
        res.ready = 1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        send(K_READ, 0, 0, 0);
        send(K_TRANSLATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send(K_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(K_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000);
        send(K_READ, 0, 0, 0);
        send(K_IDENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(K_ROT_X, 90 << 16, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(K_ROT_Y, -(90 << 16), 0, 0);
        send(K_ROT_Z, 180 << 16, 0, 0);
        send(K_READ, 0, 0, 0);
        send(K_ROT_X, 32'h7FFF_FFFF, 0, 0);
        send(K_ROT_Y, 32'h8000_0000, 0, 0);
        send(K_ROT_Z, 270 << 16, 0, 0);
        send(K_ROT_Z, -(720 << 16), 0, 0);
        send(3'd7, 32'h1234_5678, 32'hFFFF_FFFF, 0);
        send(K_READ, 0, 0, 0);
        send(K_SCALE, 0, 0, 0);
        send(K_READ, 0, 0, 0);
        send(K_IDENT, 0, 0, 0);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 60 : 30) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 60 : 30) : 0;
            for (int n = 0; n < 90; n++) random_item();
        end
        send(K_READ, 0, 0, 0);
        req.valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
sv/tma_pkg.sv
sv/tma_req_if.sv
sv/tma_res_if.sv
sv/tma_mem.sv
sv/tma_mac.sv
sv/tma_cordic.sv
sv/transform_matrix_accumulator_unit.sv
test/tma_checker.sv
test/tb.sv
